### sv/rpoc_pkg.sv
// Shared types and constants for the room placement overlap checker.
package rpoc_pkg;

  // Table size and widths.
  localparam int unsigned MAX_ROOMS = 64;
  localparam int unsigned ROOM_AW = $clog2(MAX_ROOMS);
  localparam int unsigned COUNT_W = $clog2(MAX_ROOMS + 1);

  // Grid and try budget.
  localparam int unsigned GRID_MAX = 1024;
  localparam int unsigned GRID_W = 11;
  localparam int unsigned TRIES_PER_ROOM = 10000;
  localparam int unsigned TRIES_W = 20;
  localparam logic [TRIES_W-1:0] TRIES_RESET = TRIES_W'(MAX_ROOMS * TRIES_PER_ROOM);

  // Configuration port.
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned LIMIT_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOM_LIMIT = 2'd2;

  // Command codes.
  localparam logic CMD_RESTART = 1'b0;
  localparam logic CMD_OFFER = 1'b1;

  // One stored room: left column, top row, width and height.
  typedef struct packed {
    logic [9:0] x;
    logic [9:0] y;
    logic [4:0] w;
    logic [4:0] h;
  } room_t;

  // Input word.
  typedef struct packed {
    logic       command;
    logic [9:0] cand_x;
    logic [9:0] cand_y;
    logic [4:0] cand_width;
    logic [4:0] cand_height;
  } cand_item_t;

  // Result word.
  typedef struct packed {
    logic               accepted;
    logic [ROOM_AW-1:0] room_index;
    logic [COUNT_W-1:0] rooms_placed;
    logic               finished;
  } place_result_t;

  // Access request from the sequencer to the room table.
  typedef struct packed {
    logic               we;
    logic [ROOM_AW-1:0] waddr;
    room_t              wdata;
    logic               re;
    logic [ROOM_AW-1:0] raddr;
  } mem_req_t;

endpackage

### sv/rpoc_room_mem.sv
// Room table: one write port and one registered read port.
module rpoc_room_mem (
  input  logic              clk_i,
  input  rpoc_pkg::mem_req_t req_i,
  output rpoc_pkg::room_t    rdata_o
);
  import rpoc_pkg::*;

  room_t mem [MAX_ROOMS];
  room_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/rpoc_overlap.sv
// Proximity test of a candidate against one stored room on both axes.
module rpoc_overlap (
  input  rpoc_pkg::room_t cand_i,
  input  rpoc_pkg::room_t room_i,
  output logic            near_o
);
  import rpoc_pkg::*;

  // One span widened by a cell on each side overlaps the other when the hull of
  // the raw spans is no longer than the sum of the raw widths.
  function automatic logic span_near(input logic [9:0] a, input logic [4:0] wa,
                                     input logic [9:0] b, input logic [4:0] wb);
    logic [10:0] ea;
    logic [10:0] eb;
    logic [10:0] hi;
    logic [10:0] lo;
    logic [10:0] hull;
    logic [5:0]  sum;
    ea = {1'b0, a} + {6'd0, wa};
    eb = {1'b0, b} + {6'd0, wb};
    hi = (ea > eb) ? ea : eb;
    lo = (a < b) ? {1'b0, a} : {1'b0, b};
    hull = hi - lo;
    sum = {1'b0, wa} + {1'b0, wb};
    return hull <= {5'd0, sum};
  endfunction

  assign near_o = span_near(cand_i.x, cand_i.w, room_i.x, room_i.w) &&
                  span_near(cand_i.y, cand_i.h, room_i.y, room_i.h);

endmodule

### sv/room_placement_overlap_checker.sv
// Top level of the room placement overlap checker: sequencer, registers and handshakes.
// Each word is handled alone. A restart, or a candidate offered after placement has
// finished, goes straight to the done state and is answered from there. A live
// candidate is first checked against the grid border and then against every stored
// room, one table read per cycle through a single compare unit, before it is committed.
// The next word is taken once the result has moved into the output register, which may
// still be waiting to be taken. The room table needs no clearing pass after reset.
module room_placement_overlap_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  rpoc_pkg::cand_item_t                 in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output rpoc_pkg::place_result_t              out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [rpoc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [rpoc_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import rpoc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_COMMIT = 4'b0100,
    ST_DONE   = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [GRID_W-1:0]   grid_width_q, grid_height_q;
  logic [LIMIT_W-1:0]  room_limit_q;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic [TRIES_W-1:0]  tries_q, tries_d;
  logic [COUNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic                pending_q, pending_d;
  logic                reject_q, reject_d;
  logic                acc_q, acc_d;
  logic [ROOM_AW-1:0]  slot_q, slot_d;
  room_t               cand_q, cand_d;
  logic                out_valid_q;
  place_result_t       out_data_q;

  logic [LIMIT_W-1:0]  eff_limit;
  logic [GRID_W-1:0]   eff_gw, eff_gh;
  logic                is_finished;
  logic                border_rej;
  logic                accept_in;
  logic                issue;
  logic                near;
  logic                out_load;
  room_t               rd_room;
  room_t               in_room;
  mem_req_t            mem_req;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GRID_W'(GRID_MAX);
      grid_height_q <= GRID_W'(GRID_MAX);
      room_limit_q  <= LIMIT_W'(MAX_ROOMS);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_GRID_WIDTH:  grid_width_q  <= cfg_wdata_i[GRID_W-1:0];
        CFG_GRID_HEIGHT: grid_height_q <= cfg_wdata_i[GRID_W-1:0];
        CFG_ROOM_LIMIT:  room_limit_q  <= cfg_wdata_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped bounds and the finished flag.
  assign eff_limit = (room_limit_q > LIMIT_W'(MAX_ROOMS)) ? LIMIT_W'(MAX_ROOMS)
                                                           : room_limit_q;
  assign eff_gw = (grid_width_q > GRID_W'(GRID_MAX)) ? GRID_W'(GRID_MAX) : grid_width_q;
  assign eff_gh = (grid_height_q > GRID_W'(GRID_MAX)) ? GRID_W'(GRID_MAX) : grid_height_q;
  assign is_finished = (count_q >= eff_limit) || (tries_q == '0);

  // Border test on the incoming word.
  assign in_room = '{x: in_data_i.cand_x, y: in_data_i.cand_y,
                     w: in_data_i.cand_width, h: in_data_i.cand_height};
  assign border_rej = (in_room.x == '0) || (in_room.y == '0) ||
                      (({1'b0, in_room.x} + {6'd0, in_room.w}) >= eff_gw) ||
                      (({1'b0, in_room.y} + {6'd0, in_room.h}) >= eff_gh);

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept_in  = in_valid_i && !in_stall_o;
  assign issue      = (state_q == ST_SCAN) && (rd_idx_q < count_q);
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // Table access.
  always_comb begin
    mem_req       = '0;
    mem_req.re    = issue;
    mem_req.raddr = rd_idx_q[ROOM_AW-1:0];
    mem_req.waddr = count_q[ROOM_AW-1:0];
    mem_req.wdata = cand_q;
    mem_req.we    = (state_q == ST_COMMIT) && !reject_q && (count_q < COUNT_W'(MAX_ROOMS));
  end

  rpoc_room_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rd_room)
  );

  rpoc_overlap u_overlap (
    .cand_i (cand_q),
    .room_i (rd_room),
    .near_o (near)
  );

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    tries_d   = tries_q;
    rd_idx_d  = rd_idx_q;
    pending_d = pending_q;
    reject_d  = reject_q;
    acc_d     = acc_q;
    slot_d    = slot_q;
    cand_d    = cand_q;
    case (state_q)
      ST_IDLE: begin
        if (accept_in) begin
          acc_d  = 1'b0;
          slot_d = '0;
          if (in_data_i.command == CMD_RESTART) begin
            count_d = '0;
            tries_d = TRIES_W'(eff_limit * TRIES_PER_ROOM);
            state_d = ST_DONE;
          end else if (is_finished) begin
            state_d = ST_DONE;
          end else begin
            cand_d    = in_room;
            reject_d  = border_rej;
            rd_idx_d  = '0;
            pending_d = 1'b0;
            state_d   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        pending_d = issue;
        if (issue) begin
          rd_idx_d = rd_idx_q + COUNT_W'(1);
        end
        if (pending_q && near) begin
          reject_d = 1'b1;
        end
        if (!issue && !pending_q) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (mem_req.we) begin
          acc_d   = 1'b1;
          slot_d  = count_q[ROOM_AW-1:0];
          count_d = count_q + COUNT_W'(1);
        end
        tries_d = tries_q - TRIES_W'(1);
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      tries_q   <= TRIES_RESET;
      rd_idx_q  <= '0;
      pending_q <= 1'b0;
      reject_q  <= 1'b0;
      acc_q     <= 1'b0;
      slot_q    <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      tries_q   <= tries_d;
      rd_idx_q  <= rd_idx_d;
      pending_q <= pending_d;
      reject_q  <= reject_d;
      acc_q     <= acc_d;
      slot_q    <= slot_d;
    end
  end

  // Candidate holding register.
  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.accepted     <= acc_q;
      out_data_q.room_index   <= slot_q;
      out_data_q.rooms_placed <= count_q;
      out_data_q.finished     <= is_finished;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The room count never passes the table size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_W'(MAX_ROOMS))
    else $error("room count above table size");

  // A stored room is always the newest one.
  a_index_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.accepted |->
      (out_data_o.room_index == ROOM_AW'(out_data_o.rooms_placed - COUNT_W'(1))))
    else $error("room index does not match room count");

  // The room count moves only by one step up or back to zero.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |->
      (count_q == $past(count_q) + COUNT_W'(1)) || (count_q == '0))
    else $error("room count jumped");

  // The try budget grows only by a restart.
  a_tries_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tries_q > $past(tries_q) |->
      $past(state_q == ST_IDLE && accept_in && in_data_i.command == CMD_RESTART))
    else $error("try budget grew without a restart");

endmodule
